// File: sv/cjet_pkg.sv
// Shared constants, codes and state types for the cubic Julia escape-time unit.
package cjet_pkg;

    // Default number of fraction bits of the internal fixed-point format
    localparam int FRAC_BITS_DEF = 28;

    // Width of one operand slice of the shared multiplier
    localparam int CHUNK_W = 26;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [15:0] MAX_ITER_RST = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_C_REAL   = 2'd0,
        REG_C_IMAG   = 2'd1,
        REG_MAX_ITER = 2'd2
    } cfg_reg_t;

    // Top-level sequencer
    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_X2X,
        S_Y2X,
        S_X2Y,
        S_Y2Y,
        S_UPD,
        S_TEST,
        S_DONE
    } seq_state_t;

    // Shared multiplier sequencer
    typedef enum logic [1:0] {
        MS_IDLE,
        MS_ISSUE,
        MS_DRAIN,
        MS_ROUND
    } mul_state_t;

endpackage

// File: sv/cjet_if.sv
// Valid/ready channel interfaces for points, results and register writes.
interface cjet_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] z_real;
    logic signed [31:0] z_imag;

    modport source (output valid, output z_real, output z_imag, input ready);
    modport sink   (input valid, input z_real, input z_imag, output ready);
endinterface

interface cjet_out_if;
    logic        valid;
    logic        ready;
    logic        escaped;
    logic [15:0] iter_count;
    logic [31:0] final_mag_sq;

    modport source (output valid, output escaped, output iter_count, output final_mag_sq,
                    input ready);
    modport sink   (input valid, input escaped, input iter_count, input final_mag_sq,
                    output ready);
endinterface

interface cjet_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cjet_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/cjet_mul.sv
// Shared fixed-point multiplier: sliced partial products, truncation toward zero.
module cjet_mul #(
    parameter int FRAC_BITS = cjet_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [FRAC_BITS+9:0] a,
    input  logic signed [FRAC_BITS+9:0] b,
    output logic                        done,
    output logic signed [FRAC_BITS+13:0] p
);
    import cjet_pkg::*;

    localparam int OW   = FRAC_BITS + 10;
    localparam int RW   = FRAC_BITS + 14;
    localparam int OPW  = FRAC_BITS + 9;
    localparam int NCH  = (OPW + CHUNK_W - 1) / CHUNK_W;
    localparam int PADW = NCH * CHUNK_W;
    localparam int PRW  = 2 * PADW;
    localparam int IW   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int SHW  = $clog2(PRW);

    mul_state_t             state_reg, state_next;
    logic [PADW-1:0]        am_reg, am_next;
    logic [PADW-1:0]        bm_reg, bm_next;
    logic                   neg_reg, neg_next;
    logic [IW-1:0]          i_reg, i_next;
    logic [IW-1:0]          j_reg, j_next;
    logic [2*CHUNK_W-1:0]   pp_reg, pp_next;
    logic [SHW-1:0]         sh_reg, sh_next;
    logic                   ppv_reg, ppv_next;
    logic [PRW-1:0]         acc_reg, acc_next;
    logic signed [RW-1:0]   p_reg, p_next;
    logic                   done_reg, done_next;

    logic [OW-1:0]          a_abs, b_abs;
    logic [CHUNK_W-1:0]     a_sl, b_sl;
    logic [IW:0]            pos;
    logic [RW-1:0]          mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_IDLE;
            ppv_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ppv_reg   <= ppv_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        am_reg  <= am_next;
        bm_reg  <= bm_next;
        neg_reg <= neg_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
        p_reg   <= p_next;
    end

    always_comb
    begin
        a_abs = a[OW-1] ? OW'(-a) : OW'(a);
        b_abs = b[OW-1] ? OW'(-b) : OW'(b);
        a_sl  = am_reg[i_reg*CHUNK_W +: CHUNK_W];
        b_sl  = bm_reg[j_reg*CHUNK_W +: CHUNK_W];
        pos   = (IW+1)'(i_reg) + (IW+1)'(j_reg);
        mag   = acc_reg[FRAC_BITS +: RW];

        state_next = state_reg;
        am_next    = am_reg;
        bm_next    = bm_reg;
        neg_next   = neg_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pp_next    = pp_reg;
        sh_next    = sh_reg;
        ppv_next   = 1'b0;
        p_next     = p_reg;
        done_next  = 1'b0;
        acc_next   = ppv_reg ? acc_reg + (PRW'(pp_reg) << sh_reg) : acc_reg;

        unique case (state_reg)
            MS_IDLE:
            begin
                if (start)
                begin
                    am_next    = PADW'(a_abs[OPW-1:0]);
                    bm_next    = PADW'(b_abs[OPW-1:0]);
                    neg_next   = a[OW-1] ^ b[OW-1];
                    i_next     = '0;
                    j_next     = '0;
                    acc_next   = '0;
                    state_next = MS_ISSUE;
                end
            end
            MS_ISSUE:
            begin
                // one slice pair per cycle, registered before accumulation
                pp_next  = a_sl * b_sl;
                sh_next  = SHW'(pos * CHUNK_W);
                ppv_next = 1'b1;
                if (j_reg == IW'(NCH - 1))
                begin
                    j_next = '0;
                    if (i_reg == IW'(NCH - 1))
                        state_next = MS_DRAIN;
                    else
                        i_next = i_reg + 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            MS_DRAIN:
            begin
                state_next = MS_ROUND;
            end
            MS_ROUND:
            begin
                p_next     = neg_reg ? RW'(-mag) : RW'(mag);
                done_next  = 1'b1;
                state_next = MS_IDLE;
            end
            default:
            begin
                state_next = MS_IDLE;
            end
        endcase
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

// File: sv/cubic_julia_escape_time_unit.sv
// Top level of the cubic Julia escape-time unit: sequencer, registers and channels.
//
//  channel | modport | word carries                          | accepted when
//  --------+---------+---------------------------------------+----------------------
//  pt      | sink    | z_real, z_imag (Q4.28 start point)    | pt.valid & pt.ready
//  res     | source  | escaped, iter_count, final_mag_sq     | res.valid & res.ready
//  cfg     | sink    | index, data (c_real, c_imag, max_iter)| cfg.valid & cfg.ready
//
// The shared multiplier works through N*N slice pairs per product, where N is its slice
// count (2 at 28 fraction bits).
// Reset clears the sequencer, the output valid and the registers (max_iter to 100).
// A result word waits in the output register while the next point is accepted; a new
// result is held back until that register has been taken.
module cubic_julia_escape_time_unit #(
    parameter int FRAC_BITS = cjet_pkg::FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    cjet_in_if.sink    pt,
    cjet_out_if.source res,
    cjet_cfg_if.sink   cfg
);
    import cjet_pkg::*;

    // internal widths: point F+6, squares F+10, products F+14, sums F+16, magnitude F+10
    localparam int XW     = FRAC_BITS + 6;
    localparam int SW     = FRAC_BITS + 10;
    localparam int OW     = FRAC_BITS + 10;
    localparam int RW     = FRAC_BITS + 14;
    localparam int AW     = FRAC_BITS + 16;
    localparam int MAGW   = FRAC_BITS + 10;
    localparam int IN_UP  = (FRAC_BITS >= 28) ? FRAC_BITS - 28 : 0;
    localparam int IN_DN  = (FRAC_BITS < 28) ? 28 - FRAC_BITS : 0;
    localparam int OUT_DN = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;
    localparam int OUT_UP = (FRAC_BITS < 24) ? 24 - FRAC_BITS : 0;
    localparam int QW     = MAGW + OUT_UP;

    // ---------------------------------------------------------------- registers
    logic signed [31:0] c_real_reg, c_real_next;
    logic signed [31:0] c_imag_reg, c_imag_next;
    logic [15:0]        max_iter_reg, max_iter_next;

    // ---------------------------------------------------------------- datapath
    seq_state_t          state_reg, state_next;
    logic                pend_reg, pend_next;
    logic                first_reg, first_next;
    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [SW-1:0] x2_reg, x2_next;
    logic signed [SW-1:0] y2_reg, y2_next;
    logic signed [AW-1:0] ax_reg, ax_next;
    logic signed [AW-1:0] ay_reg, ay_next;
    logic [15:0]          iter_reg, iter_next;
    logic                 esc_reg, esc_next;
    logic [15:0]          cnt_reg, cnt_next;
    logic [31:0]          mag_reg, mag_next;

    // output register
    logic                 ovld_reg, ovld_next;
    logic                 oesc_reg, oesc_next;
    logic [15:0]          ocnt_reg, ocnt_next;
    logic [31:0]          omag_reg, omag_next;

    // multiplier hookup
    logic                 mul_start;
    logic signed [OW-1:0] mul_a, mul_b;
    logic                 mul_done;
    logic signed [RW-1:0] mul_p;
    logic signed [AW-1:0] pw;

    // combinational helpers
    logic signed [AW-1:0] cr, ci;
    logic signed [AW-1:0] zr_int, zi_int;
    logic [MAGW-1:0]      mag_sum;
    logic [QW-1:0]        mag_q;
    logic [16:0]          iter_inc;

    function automatic logic signed [XW-1:0] clamp16(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] bound;
        bound = AW'(1) <<< (FRAC_BITS + 4);
        if (v > bound)
            clamp16 = XW'(bound);
        else if (v < -bound)
            clamp16 = XW'(-bound);
        else
            clamp16 = XW'(v);
    endfunction

    cjet_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    // Q4.28 to internal format: scale up, or shift right with floor
    assign cr     = (AW'(c_real_reg) <<< IN_UP) >>> IN_DN;
    assign ci     = (AW'(c_imag_reg) <<< IN_UP) >>> IN_DN;
    assign zr_int = (AW'(pt.z_real) <<< IN_UP) >>> IN_DN;
    assign zi_int = (AW'(pt.z_imag) <<< IN_UP) >>> IN_DN;
    assign pw     = AW'(mul_p);

    // squares are never negative; drop their sign bit before adding
    assign mag_sum  = MAGW'(x2_reg[SW-2:0]) + MAGW'(y2_reg[SW-2:0]);
    assign mag_q    = (QW'(mag_sum) >> OUT_DN) << OUT_UP;
    assign iter_inc = 17'(iter_reg) + 17'd1;

    assign pt.ready         = (state_reg == S_IDLE);
    assign cfg.ready        = 1'b1;
    assign res.valid        = ovld_reg;
    assign res.escaped      = oesc_reg;
    assign res.iter_count   = ocnt_reg;
    assign res.final_mag_sq = omag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pend_reg     <= 1'b0;
            ovld_reg     <= 1'b0;
            c_real_reg   <= '0;
            c_imag_reg   <= '0;
            max_iter_reg <= MAX_ITER_RST;
        end
        else
        begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            ovld_reg     <= ovld_next;
            c_real_reg   <= c_real_next;
            c_imag_reg   <= c_imag_next;
            max_iter_reg <= max_iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        x2_reg    <= x2_next;
        y2_reg    <= y2_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        iter_reg  <= iter_next;
        esc_reg   <= esc_next;
        cnt_reg   <= cnt_next;
        mag_reg   <= mag_next;
        oesc_reg  <= oesc_next;
        ocnt_reg  <= ocnt_next;
        omag_reg  <= omag_next;
    end

    // Register decoder: a write to an index past the list is dropped.
    always_comb
    begin
        c_real_next   = c_real_reg;
        c_imag_next   = c_imag_reg;
        max_iter_next = max_iter_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_C_REAL:   c_real_next   = cfg.data;
                REG_C_IMAG:   c_imag_next   = cfg.data;
                REG_MAX_ITER: max_iter_next = cfg.data[15:0];
                default:      ;
            endcase
        end
    end

    // Sequencer: per step run six products on the shared multiplier, then clamp
    // and test. Square terms of the tested point carry over into the next step.
    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        first_next = first_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        x2_next    = x2_reg;
        y2_next    = y2_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        iter_next  = iter_reg;
        esc_next   = esc_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        ovld_next  = ovld_reg;
        oesc_next  = oesc_reg;
        ocnt_next  = ocnt_reg;
        omag_next  = omag_reg;
        mul_start  = 1'b0;
        mul_a      = OW'(x_reg);
        mul_b      = OW'(x_reg);

        // drop the output word once taken
        if (ovld_reg && res.ready)
            ovld_next = 1'b0;

        // operand selection for the product states
        unique case (state_reg)
            S_SQY:
            begin
                mul_a = OW'(y_reg);
                mul_b = OW'(y_reg);
            end
            S_X2X:
            begin
                mul_a = OW'(x2_reg);
                mul_b = OW'(x_reg);
            end
            S_Y2X:
            begin
                mul_a = OW'(y2_reg);
                mul_b = OW'(x_reg);
            end
            S_X2Y:
            begin
                mul_a = OW'(x2_reg);
                mul_b = OW'(y_reg);
            end
            S_Y2Y:
            begin
                mul_a = OW'(y2_reg);
                mul_b = OW'(y_reg);
            end
            default:
            begin
                mul_a = OW'(x_reg);
                mul_b = OW'(x_reg);
            end
        endcase

        // issue one product per state, then wait for it
        if (state_reg == S_SQX || state_reg == S_SQY || state_reg == S_X2X ||
            state_reg == S_Y2X || state_reg == S_X2Y || state_reg == S_Y2Y)
        begin
            if (!pend_reg)
            begin
                mul_start = 1'b1;
                pend_next = 1'b1;
            end
            else if (mul_done)
            begin
                pend_next = 1'b0;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (pt.valid)
                begin
                    x_next     = zr_int[XW-1:0];
                    y_next     = zi_int[XW-1:0];
                    iter_next  = '0;
                    first_next = 1'b1;
                    state_next = S_SQX;
                end
            end
            S_SQX:
            begin
                if (pend_reg && mul_done)
                begin
                    x2_next    = mul_p[SW-1:0];
                    state_next = S_SQY;
                end
            end
            S_SQY:
            begin
                if (pend_reg && mul_done)
                begin
                    y2_next = mul_p[SW-1:0];
                    if (!first_reg)
                    begin
                        state_next = S_TEST;
                    end
                    else if (max_iter_reg == '0)
                    begin
                        // no step to run: report a point that stays inside
                        esc_next   = 1'b0;
                        cnt_next   = '0;
                        mag_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_X2X;
                    end
                end
            end
            S_X2X:
            begin
                if (pend_reg && mul_done)
                begin
                    ax_next    = pw + cr;
                    state_next = S_Y2X;
                end
            end
            S_Y2X:
            begin
                if (pend_reg && mul_done)
                begin
                    ax_next    = ax_reg - pw - (pw <<< 1);
                    state_next = S_X2Y;
                end
            end
            S_X2Y:
            begin
                if (pend_reg && mul_done)
                begin
                    ay_next    = pw + (pw <<< 1) + ci;
                    state_next = S_Y2Y;
                end
            end
            S_Y2Y:
            begin
                if (pend_reg && mul_done)
                begin
                    ay_next    = ay_reg - pw;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                // clamp the new point to +/-16 before squaring
                x_next     = clamp16(ax_reg);
                y_next     = clamp16(ay_reg);
                first_next = 1'b0;
                state_next = S_SQX;
            end
            S_TEST:
            begin
                if (mag_sum > (MAGW'(1) << (FRAC_BITS + 2)))
                begin
                    esc_next   = 1'b1;
                    cnt_next   = iter_reg;
                    mag_next   = (|mag_q[QW-1:32]) ? '1 : mag_q[31:0];
                    state_next = S_DONE;
                end
                else if (iter_inc == 17'(max_iter_reg))
                begin
                    esc_next   = 1'b0;
                    cnt_next   = '0;
                    mag_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    iter_next  = iter_inc[15:0];
                    state_next = S_X2X;
                end
            end
            S_DONE:
            begin
                // hold the result until the output register is free
                if (!ovld_reg || res.ready)
                begin
                    ovld_next  = 1'b1;
                    oesc_next  = esc_reg;
                    ocnt_next  = cnt_reg;
                    omag_next  = mag_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
